// ----- sv/battery_level_gauge_hysteresis_top_assert.svh -----
// Assertion macros for the battery level gauge top level.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef BATTERY_LEVEL_GAUGE_HYSTERESIS_TOP_ASSERT_SVH
`define BATTERY_LEVEL_GAUGE_HYSTERESIS_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BLGH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BLGH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/blgh_pkg.sv -----
// Shared widths, thresholds and stage structs for the battery level gauge.
// No dependencies.
package blgh_pkg;

	localparam int HIGH_SUM_W = 11;
	localparam int LOW_SUM_W  = 7;
	localparam int SECS_W     = 16;
	localparam int LEVEL_W    = 4;
	localparam int RD_W       = 12;
	localparam int RAW_W      = 13;
	localparam int RUN_W      = 4;

	// low readings must repeat this many times before they count
	localparam int LOW_DEBOUNCE = 10;
	localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(LOW_DEBOUNCE);

	localparam logic [RAW_W-1:0] TEST_READING = 13'd1550;
	localparam logic [RAW_W-1:0] HIGH_LIMIT   = 13'd1550;
	localparam logic [RAW_W-1:0] LOW_LIMIT    = 13'd1150;

	localparam logic [SECS_W-1:0] OVERTIME_SECS = 16'd600;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 4'd8;

	// reading stage to level stage
	typedef struct packed {
		logic              debouncing;
		logic              zero_level;
		logic [RUN_W-1:0]  low_run_nxt;
		logic [RD_W-1:0]   raw_rd;
		logic [RD_W-1:0]   adj_rd;
	} rd_res_t;

	// level stage to result register and state
	typedef struct packed {
		logic [LEVEL_W-1:0] level_nxt;
		logic [LEVEL_W-1:0] held_nxt;
		logic [RD_W-1:0]    adj_rd;
		logic [SECS_W-1:0]  secs_nxt;
		logic               clr_full;
	} lvl_res_t;

endpackage

// ----- sv/blgh_if.sv -----
// Valid/ready channel interfaces for ADC words in and gauge words out.
// Depends on blgh_pkg.
interface blgh_in_if;
	logic                              valid;
	logic                              ready;
	logic [blgh_pkg::HIGH_SUM_W-1:0]   high_sum;
	logic [blgh_pkg::LOW_SUM_W-1:0]    low_sum;
	logic                              charging;
	logic [blgh_pkg::SECS_W-1:0]       charge_seconds;

	modport source (output valid, high_sum, low_sum, charging, charge_seconds, input ready);
	modport sink (input valid, high_sum, low_sum, charging, charge_seconds, output ready);
endinterface

interface blgh_out_if;
	logic                              valid;
	logic                              ready;
	logic [blgh_pkg::LEVEL_W-1:0]      battery_level;
	logic [blgh_pkg::RD_W-1:0]         adjusted_reading;
	logic [blgh_pkg::SECS_W-1:0]       charge_seconds_next;
	logic                              clear_full_count;

	modport source (output valid, battery_level, adjusted_reading, charge_seconds_next,
		clear_full_count, input ready);
	modport sink (input valid, battery_level, adjusted_reading, charge_seconds_next,
		clear_full_count, output ready);
endinterface

// ----- sv/blgh_reading.sv -----
// Average reading, low debounce, offset and charging correction.
// Depends on blgh_pkg.
module blgh_reading (
	input  logic [blgh_pkg::HIGH_SUM_W-1:0] high_sum,
	input  logic [blgh_pkg::LOW_SUM_W-1:0]  low_sum,
	input  logic                            charging,
	input  logic                            force_rd,
	input  logic [blgh_pkg::RUN_W-1:0]      low_run,
	output blgh_pkg::rd_res_t               rd
);
	import blgh_pkg::*;

	logic [RD_W-1:0]  sum;
	logic [RAW_W-1:0] raw;
	logic [RAW_W-1:0] eff;
	logic [RAW_W-1:0] offs;
	logic [RUN_W-1:0] run_inc;
	logic [RD_W-1:0]  off12;

	// (high*16 + low&0xF0) / 8 collapses to (high + low[6:4]) * 2
	assign sum = {1'b0, high_sum} + {{(RD_W-3){1'b0}}, low_sum[6:4]};
	assign raw = force_rd ? TEST_READING : {sum, 1'b0};
	assign run_inc = (low_run < RUN_MAX) ? low_run + 1'b1 : low_run;

	always_comb begin
		// window check and debounce
		rd.debouncing  = 1'b0;
		rd.zero_level  = 1'b0;
		rd.low_run_nxt = '0;
		rd.raw_rd      = raw[RD_W-1:0];
		eff            = raw;
		if (raw < LOW_LIMIT) begin
			rd.low_run_nxt = run_inc;
			if (run_inc < RUN_MAX) begin
				rd.debouncing = 1'b1;
			end else begin
				rd.zero_level = 1'b1;
				eff           = LOW_LIMIT;
			end
		end

		offs  = eff - LOW_LIMIT;
		off12 = offs[RD_W-1:0];

		// charging lifts the cell voltage; pull it back by band
		rd.adj_rd = off12;
		if (charging && off12 < 12'd390) begin
			if (off12 > 12'd360)
				rd.adj_rd = off12 - 12'd10;
			else if (off12 > 12'd300)
				rd.adj_rd = off12 - 12'd20;
			else if (off12 > 12'd200)
				rd.adj_rd = off12 - 12'd30;
			else if (off12 > 12'd50)
				rd.adj_rd = off12 - 12'd40;
		end
	end

endmodule

// ----- sv/blgh_level.sv -----
// Band mapping with hysteresis, full and overtime rules, and the level hold.
// Depends on blgh_pkg.
module blgh_level (
	input  blgh_pkg::rd_res_t              rd,
	input  logic                           charging,
	input  logic [blgh_pkg::SECS_W-1:0]    secs,
	input  logic [blgh_pkg::LEVEL_W-1:0]   level,
	input  logic [blgh_pkg::LEVEL_W-1:0]   held,
	output blgh_pkg::lvl_res_t             res
);
	import blgh_pkg::*;

	logic [LEVEL_W-1:0] lv;
	logic [LEVEL_W-1:0] hd;
	logic [SECS_W-1:0]  sc;
	logic [RD_W-1:0]    r;
	logic               clr;

	always_comb begin
		r   = rd.adj_rd;
		sc  = secs;
		clr = 1'b0;
		lv  = rd.zero_level ? '0 : level;
		hd  = held;

		// full and nearly full
		if (r >= 12'd398)
			lv = 4'd7;
		if (r >= 12'd402) begin
			lv = LEVEL_FULL;
		end else if (r > 12'd380) begin
			if (lv < 4'd6) begin
				clr = 1'b1;
				if (r > 12'd382)
					lv = 4'd6;
			end else if (sc == '0 && r < 12'd396) begin
				lv  = 4'd6;
				clr = 1'b1;
			end
			// overtime at level six
			if (sc > OVERTIME_SECS && r > 12'd395) begin
				sc = OVERTIME_SECS;
				lv = 4'd7;
			end
		end else if (r > 12'd360) begin
			if (!(lv > 4'd5 && r >= 12'd380)) lv = 4'd5;
			sc = '0;
		end else if (r > 12'd330) begin
			if (!(lv > 4'd4 && r >= 12'd360)) lv = 4'd4;
			sc = '0;
		end else if (r > 12'd290) begin
			if (!(lv > 4'd3 && r >= 12'd340)) lv = 4'd3;
			sc = '0;
		end else if (r > 12'd180) begin
			if (!(lv > 4'd2 && r >= 12'd240)) lv = 4'd2;
			sc = '0;
		end else if (r > 12'd0) begin
			if (!(lv > 4'd1 && r >= 12'd170)) lv = 4'd1;
			sc = '0;
		end

		// hold: rise only while charging, fall only otherwise
		if (charging) begin
			if (lv > hd) hd = lv;
		end else begin
			if (lv < hd) hd = lv;
		end
		if (hd != '0)
			lv = hd;

		// a low reading still in debounce changes nothing
		if (rd.debouncing) begin
			res.level_nxt = level;
			res.held_nxt  = held;
			res.adj_rd    = rd.raw_rd;
			res.secs_nxt  = secs;
			res.clr_full  = 1'b0;
		end else begin
			res.level_nxt = lv;
			res.held_nxt  = hd;
			res.adj_rd    = r;
			res.secs_nxt  = sc;
			res.clr_full  = clr;
		end
	end

endmodule

// ----- sv/battery_level_gauge_hysteresis_top.sv -----
// Battery level gauge: input register, one pass of reading and level logic, result register.
// Words pass input then result register; level, hold and debounce state update once per word.
// Throughput: 1 word per cycle while result.ready does not stall the output.
// Reset (arst_n low, asynchronous): level, hold, debounce count, test flag and valids cleared.
// Depends on blgh_pkg, blgh_if, blgh_reading, blgh_level and the assertion header.
`include "battery_level_gauge_hysteresis_top_assert.svh"

module battery_level_gauge_hysteresis_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	blgh_in_if.sink     adc,
	blgh_out_if.source  result
);
	import blgh_pkg::*;

	// input stage
	logic                  valid_s1;
	logic [HIGH_SUM_W-1:0] high_sum_s1;
	logic [LOW_SUM_W-1:0]  low_sum_s1;
	logic                  charging_s1;
	logic [SECS_W-1:0]     secs_s1;

	// state and config
	logic                  force_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [LEVEL_W-1:0]    held_q;
	logic [RUN_W-1:0]      low_run_q;

	// result register
	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    bl_q;
	logic [RD_W-1:0]       adj_q;
	logic [SECS_W-1:0]     secs_q;
	logic                  clr_q;

	logic                  out_free;
	logic                  adv_s1;
	logic                  take_in;
	rd_res_t               rd;
	lvl_res_t              lvl;

	// handshake
	assign out_free  = !out_valid_q || result.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign adc.ready = !valid_s1 || out_free;
	assign take_in   = adc.valid && adc.ready;

	// test flag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_q <= 1'b0;
		end else if (cfg_we) begin
			force_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adc.ready) begin
			valid_s1 <= adc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			high_sum_s1 <= adc.high_sum;
			low_sum_s1  <= adc.low_sum;
			charging_s1 <= adc.charging;
			secs_s1     <= adc.charge_seconds;
		end
	end

	blgh_reading u_reading (
		.high_sum (high_sum_s1),
		.low_sum  (low_sum_s1),
		.charging (charging_s1),
		.force_rd (force_q),
		.low_run  (low_run_q),
		.rd       (rd)
	);

	blgh_level u_level (
		.rd       (rd),
		.charging (charging_s1),
		.secs     (secs_s1),
		.level    (level_q),
		.held     (held_q),
		.res      (lvl)
	);

	// gauge state, updated as each word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			held_q    <= '0;
			low_run_q <= '0;
		end else if (adv_s1) begin
			level_q   <= lvl.level_nxt;
			held_q    <= lvl.held_nxt;
			low_run_q <= rd.low_run_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			bl_q   <= lvl.level_nxt;
			adj_q  <= lvl.adj_rd;
			secs_q <= lvl.secs_nxt;
			clr_q  <= lvl.clr_full;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.battery_level       = bl_q;
	assign result.adjusted_reading    = adj_q;
	assign result.charge_seconds_next = secs_q;
	assign result.clear_full_count    = clr_q;

	// checks
	`BLGH_ASSERT_IMP(a_run_sat, 1'b1, low_run_q <= RUN_MAX, "debounce count past limit")
	`BLGH_ASSERT_IMP(a_level_range, 1'b1, level_q <= LEVEL_FULL, "level above full")
	`BLGH_ASSERT_IMP(a_hold_follow, held_q != '0, level_q == held_q, "level differs from hold")
	`BLGH_ASSERT_NEXT(a_debounce_keep, adv_s1 && rd.debouncing, $stable(level_q) && $stable(held_q),
		"level moved during low debounce")

endmodule
